// ===== hdl/raeu_pkg.sv =====
// shared types, command codes and defaults for the register alu execute unit
package raeu_pkg;

    localparam int NUM_REGS_DEF   = 5;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 5;
    localparam int SEL_W          = 3;
    localparam int IMM_W          = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 5'd0,
        CMD_MOVR  = 5'd1,
        CMD_ADD   = 5'd2,
        CMD_SUB   = 5'd3,
        CMD_MUL   = 5'd4,
        CMD_MOD   = 5'd5,
        CMD_DIV   = 5'd6,
        CMD_INC   = 5'd7,
        CMD_DEC   = 5'd8,
        CMD_EQ    = 5'd9,
        CMD_GEQ   = 5'd10,
        CMD_LEQ   = 5'd11,
        CMD_GOTO  = 5'd12,
        CMD_JMPZ  = 5'd13,
        CMD_JPNZ  = 5'd14,
        CMD_SHIFT = 5'd15,
        CMD_NOP   = 5'd16
    } cmd_t;

    localparam logic [SEL_W-1:0] SEL_M = 3'd5;
    localparam logic [SEL_W-1:0] SEL_X = 3'd6;
    localparam logic [SEL_W-1:0] SEL_S = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_BASE = 1'b1;

    // classified instruction as it travels through the queue
    typedef struct packed {
        cmd_t             cmd;
        logic [SEL_W-1:0] sel_a;
        logic [SEL_W-1:0] sel_b;
        logic [IMM_W-1:0] imm;
        logic             is_div;
        logic             is_mul;
    } instr_t;

endpackage

// ===== hdl/raeu_front.sv =====
// front end: accepts instruction beats, classifies them, holds them in a short queue
module raeu_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [4:0]                cmd,
    input  logic [2:0]                sel_a,
    input  logic [2:0]                sel_b,
    input  logic signed [31:0]        immediate,
    output logic                      q_valid,
    input  logic                      q_ready,
    output raeu_pkg::instr_t          q_data
);

    localparam int PTR_W = $clog2(raeu_pkg::QUEUE_DEPTH);

    raeu_pkg::instr_t       mem_reg [raeu_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;
    raeu_pkg::instr_t       classified;
    logic                   push, pop;

    // decode into the queue entry; unknown codes become nop
    always_comb
    begin
        classified.sel_a = sel_a;
        classified.sel_b = sel_b;
        classified.imm   = immediate;
        if (cmd > raeu_pkg::CMD_NOP)
            classified.cmd = raeu_pkg::CMD_NOP;
        else
            classified.cmd = raeu_pkg::cmd_t'(cmd);
        classified.is_div = (classified.cmd == raeu_pkg::CMD_DIV) ||
                            (classified.cmd == raeu_pkg::CMD_MOD);
        classified.is_mul = (classified.cmd == raeu_pkg::CMD_MUL);
    end

    assign in_ready = (count_reg != (PTR_W+1)'(raeu_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_data   = mem_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= classified;
    end

endmodule

// ===== hdl/raeu_divider.sv =====
// iterative unsigned divider, one quotient bit per cycle
module raeu_divider
#(
    parameter int DATA_WIDTH = raeu_pkg::DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DATA_WIDTH:0]   trial;

    assign trial = {rem_reg, quo_reg[DATA_WIDTH-1]} - {1'b0, dvs_reg};

    // restoring shift-subtract step
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_WIDTH);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[DATA_WIDTH])
            begin
                rem_next = {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/raeu_back.sv =====
// back end: register file, execution sequencer and result register
module raeu_back
#(
    parameter int NUM_REGS   = raeu_pkg::NUM_REGS_DEF,
    parameter int DATA_WIDTH = raeu_pkg::DATA_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  raeu_pkg::instr_t          q_data,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [31:0]               cfg_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [31:0]        acc_value,
    output logic signed [31:0]        pc_value,
    output logic signed [31:0]        stack_cursor,
    output logic                      div_zero
);

    localparam int SH_W = $clog2(DATA_WIDTH);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_PROD  = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [DATA_WIDTH-1:0]        rf_reg [NUM_REGS];
    logic [DATA_WIDTH-1:0]        sp_reg, pc_reg, cb_reg, xb_reg;
    raeu_pkg::instr_t             ins_reg;
    logic [DATA_WIDTH-1:0]        a_reg, b_reg;
    logic [DATA_WIDTH-1:0]        prod_reg;
    logic                         dz_reg;
    logic [DATA_WIDTH-1:0]        a_val, b_val, imm_ext, wr_val, acc_new;
    logic                         wr_sel_en, acc_en, pc_en, dz_set;
    logic [DATA_WIDTH-1:0]        pc_new;
    logic                         div_start, div_done;
    logic [DATA_WIDTH-1:0]        div_q, div_r, mag_a, mag_b;
    logic [31:0]                  sh_neg;
    logic [SH_W-1:0]              sh_amt;
    logic                         take;

    // selector read
    function automatic logic [DATA_WIDTH-1:0] read_sel(
        input logic [2:0] sel,
        input logic [DATA_WIDTH-1:0] cb,
        input logic [DATA_WIDTH-1:0] xb,
        input logic [DATA_WIDTH-1:0] sp,
        input logic [DATA_WIDTH-1:0] rf [NUM_REGS]);
        logic [DATA_WIDTH-1:0] v;
        v = '0;
        if (sel == raeu_pkg::SEL_M)
            v = cb;
        else if (sel == raeu_pkg::SEL_X)
            v = xb;
        else if (sel == raeu_pkg::SEL_S)
            v = sp;
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
                if (32'(sel) == i)
                    v = rf[i];
        end
        return v;
    endfunction

    assign take    = (state_reg == ST_IDLE) && q_valid;
    assign q_ready = (state_reg == ST_IDLE);
    assign a_val   = read_sel(q_data.sel_a, cb_reg, xb_reg, sp_reg, rf_reg);
    assign b_val   = read_sel(q_data.sel_b, cb_reg, xb_reg, sp_reg, rf_reg);
    assign imm_ext = DATA_WIDTH'($signed(ins_reg.imm));

    // operand magnitudes for the divider
    assign mag_a     = a_reg[DATA_WIDTH-1] ? -a_reg : a_reg;
    assign mag_b     = b_reg[DATA_WIDTH-1] ? -b_reg : b_reg;
    assign div_start = (state_reg == ST_DIV);
    assign sh_neg    = -ins_reg.imm;

    raeu_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_a),
        .divisor   (mag_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // shift amount saturated to DATA_WIDTH-1
    always_comb
    begin
        if (ins_reg.imm[31])
            sh_amt = (sh_neg > 32'(DATA_WIDTH-1)) ? SH_W'(DATA_WIDTH-1) : sh_neg[SH_W-1:0];
        else
            sh_amt = (ins_reg.imm > 32'(DATA_WIDTH-1)) ? SH_W'(DATA_WIDTH-1)
                                                      : ins_reg.imm[SH_W-1:0];
    end

    // result of the instruction held in ins_reg, applied in the writeback cycle
    always_comb
    begin
        wr_sel_en = 1'b0;
        wr_val    = '0;
        acc_en    = 1'b0;
        acc_new   = '0;
        pc_en     = 1'b0;
        pc_new    = '0;
        dz_set    = 1'b0;
        unique case (ins_reg.cmd)
            raeu_pkg::CMD_LOAD:  begin wr_sel_en = 1'b1; wr_val = imm_ext; end
            raeu_pkg::CMD_MOVR:  begin wr_sel_en = 1'b1; wr_val = b_reg; end
            raeu_pkg::CMD_ADD:   begin acc_en = 1'b1; acc_new = a_reg + b_reg; end
            raeu_pkg::CMD_SUB:   begin acc_en = 1'b1; acc_new = a_reg - b_reg; end
            raeu_pkg::CMD_MUL:   begin acc_en = 1'b1; acc_new = prod_reg; end
            raeu_pkg::CMD_MOD:
            begin
                if (b_reg == '0)
                    dz_set = 1'b1;
                else
                begin
                    acc_en  = 1'b1;
                    acc_new = a_reg[DATA_WIDTH-1] ? -div_r : div_r;
                end
            end
            raeu_pkg::CMD_DIV:
            begin
                if (b_reg == '0)
                    dz_set = 1'b1;
                else
                begin
                    acc_en  = 1'b1;
                    acc_new = (a_reg[DATA_WIDTH-1] != b_reg[DATA_WIDTH-1]) ? -div_q : div_q;
                end
            end
            raeu_pkg::CMD_INC:   begin wr_sel_en = 1'b1; wr_val = a_reg + 1'b1; end
            raeu_pkg::CMD_DEC:   begin wr_sel_en = 1'b1; wr_val = a_reg - 1'b1; end
            raeu_pkg::CMD_EQ:
            begin
                acc_en  = 1'b1;
                acc_new = DATA_WIDTH'(a_reg == b_reg);
            end
            raeu_pkg::CMD_GEQ:
            begin
                acc_en  = 1'b1;
                acc_new = DATA_WIDTH'($signed(a_reg) >= $signed(b_reg));
            end
            raeu_pkg::CMD_LEQ:
            begin
                acc_en  = 1'b1;
                acc_new = DATA_WIDTH'($signed(a_reg) <= $signed(b_reg));
            end
            raeu_pkg::CMD_GOTO:  begin pc_en = 1'b1; pc_new = a_reg; end
            raeu_pkg::CMD_JMPZ:  begin pc_en = (rf_reg[0] == '0); pc_new = imm_ext; end
            raeu_pkg::CMD_JPNZ:  begin pc_en = (rf_reg[0] != '0); pc_new = imm_ext; end
            raeu_pkg::CMD_SHIFT:
            begin
                wr_sel_en = (ins_reg.imm != '0);
                if (ins_reg.imm[31])
                    wr_val = a_reg << sh_amt;
                else
                    wr_val = DATA_WIDTH'($signed(a_reg) >>> sh_amt);
            end
            raeu_pkg::CMD_NOP:   begin end
            default:             begin end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.is_mul)
                        state_next = ST_PROD;
                    else if (q_data.is_div)
                        state_next = (b_val == '0) ? ST_MUL : ST_DIV;
                    else
                        state_next = ST_MUL;
                end
            end
            // product register loads from the captured operands
            ST_PROD: state_next = ST_MUL;
            ST_DIV:  state_next = ST_WAIT;
            ST_WAIT: state_next = div_done ? ST_MUL : ST_WAIT;
            ST_MUL:  state_next = ST_OUT;
            ST_OUT:  state_next = out_ready ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sp_reg    <= '0;
            pc_reg    <= '0;
            cb_reg    <= '0;
            xb_reg    <= '0;
            dz_reg    <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
                rf_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == raeu_pkg::CFG_CODE_BASE)
                    cb_reg <= DATA_WIDTH'($signed(cfg_data));
                else
                    xb_reg <= DATA_WIDTH'($signed(cfg_data));
            end
            // writeback on the last cycle before the result shows
            if (state_reg == ST_MUL)
            begin
                dz_reg <= dz_set;
                if (pc_en)
                    pc_reg <= pc_new;
                if (wr_sel_en && ins_reg.sel_a == raeu_pkg::SEL_S)
                    sp_reg <= wr_val;
                for (int i = 0; i < NUM_REGS; i++)
                begin
                    if (wr_sel_en && ins_reg.sel_a < raeu_pkg::SEL_M &&
                        32'(ins_reg.sel_a) == i)
                        rf_reg[i] <= wr_val;
                end
                if (acc_en)
                    rf_reg[0] <= acc_new;
            end
        end
    end

    // operand capture and product register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ins_reg <= q_data;
            a_reg   <= a_val;
            b_reg   <= b_val;
        end
        prod_reg <= a_reg * b_reg;
    end

    assign out_valid    = (state_reg == ST_OUT);
    assign acc_value    = 32'($signed(rf_reg[0]));
    assign pc_value     = 32'($signed(pc_reg));
    assign stack_cursor = 32'($signed(sp_reg));
    assign div_zero     = dz_reg;

endmodule

// ===== hdl/register_alu_execute_unit.sv =====
// top level of the register alu execute unit
//
// in channel: in_valid/in_ready carry one instruction beat (cmd, sel_a,
// sel_b, immediate). out channel: out_valid/out_ready carry one result beat
// per instruction (acc_value, pc_value, stack_cursor, div_zero).
// a two-entry queue sits between the front end and the execution back end,
// so up to two beats are taken while the back end is busy or stalled.
// from the queue head being taken to its result beat, most instructions
// pass through operand capture, writeback and the result beat; mul adds
// the product register; div and mod with a nonzero divisor add the divider
// start and the wait on the one-bit-per-cycle restoring divider.
// the back end takes the next instruction from the queue only after the
// previous result beat is taken, so a receiver that leaves a result beat
// waiting holds back the following instructions.
// configuration: cfg_we with cfg_index 0 writes the code base, 1 the stack
// base; write only while no beat is in flight.
// reset: asynchronous, clears the register file, stack cursor, program
// counter, both bases and the queue. a stalled result holds until taken.
module register_alu_execute_unit
#(
    parameter int NUM_REGS   = raeu_pkg::NUM_REGS_DEF,
    parameter int DATA_WIDTH = raeu_pkg::DATA_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [4:0]          cmd,
    input  logic [2:0]          sel_a,
    input  logic [2:0]          sel_b,
    input  logic signed [31:0]  immediate,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  acc_value,
    output logic signed [31:0]  pc_value,
    output logic signed [31:0]  stack_cursor,
    output logic                div_zero
);

    logic             q_valid, q_ready;
    raeu_pkg::instr_t q_data;

    // front end with queue
    raeu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .sel_a     (sel_a),
        .sel_b     (sel_b),
        .immediate (immediate),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data)
    );

    // execution back end
    raeu_back #(.NUM_REGS(NUM_REGS), .DATA_WIDTH(DATA_WIDTH)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .acc_value    (acc_value),
        .pc_value     (pc_value),
        .stack_cursor (stack_cursor),
        .div_zero     (div_zero)
    );

endmodule

// ===== hdl/raeu_checker.sv =====
// port-level checker for the register alu execute unit, with its bind
module raeu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] acc_value,
    input logic        div_zero
);

    // a stalled result beat holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(acc_value))
        else $error("result beat changed while stalled");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result beat right after reset");

    // a result beat is not shown again once it has been taken
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result beat repeated");

    // accumulator and divide-by-zero flag change only as a new result beat appears
    a_fields_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable({acc_value, div_zero}) |-> $rose(out_valid))
        else $error("result fields changed outside a new result beat");

    // an offered instruction beat stays offered until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("instruction beat withdrawn before being taken");

endmodule

bind register_alu_execute_unit raeu_checker u_raeu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .acc_value (acc_value),
    .div_zero  (div_zero)
);

// ===== tb/tb_register_alu_execute_unit.sv =====
// self-checking testbench for the register alu execute unit
module tb_register_alu_execute_unit;

    localparam int  ITEM_COUNT  = 1850;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_WAIT  = 60;

    // one expected result beat
    typedef struct {
        logic [31:0] acc;
        logic [31:0] pc;
        logic [31:0] sp;
        logic        dz;
    } result_t;

    int error_count = 0;

    // report one mismatch and count it
    task automatic report_error(input string msg);
        $display("error: %s", msg);
        error_count++;
    endtask

    // architectural shadow of the unit and the store of expected result beats
    class alu_scoreboard;
        logic [31:0] regs [5];
        logic [31:0] sp;
        logic [31:0] pc;
        logic [31:0] code_base;
        logic [31:0] stack_base;
        result_t     pending [$];

        function new();
            foreach (regs[i]) regs[i] = '0;
            sp = '0;
            pc = '0;
            code_base = '0;
            stack_base = '0;
        endfunction

        function logic [31:0] read_sel(input logic [2:0] sel);
            if (sel == raeu_pkg::SEL_M) return code_base;
            if (sel == raeu_pkg::SEL_X) return stack_base;
            if (sel == raeu_pkg::SEL_S) return sp;
            return regs[sel];
        endfunction

        function void write_sel(input logic [2:0] sel, input logic [31:0] v);
            if (sel == raeu_pkg::SEL_S) sp = v;
            else if (sel < raeu_pkg::SEL_M) regs[sel] = v;
        endfunction

        // execute one accepted instruction beat
        function void note_instr(input logic [4:0] op, input logic [2:0] sa,
                                 input logic [2:0] sb, input logic [31:0] imm);
            logic signed [31:0] a;
            logic signed [31:0] b;
            logic [31:0]        ma;
            logic [31:0]        mb;
            logic [31:0]        r;
            logic [31:0]        n;
            logic               dz;
            result_t            res;
            a  = read_sel(sa);
            b  = read_sel(sb);
            dz = 1'b0;
            case (op)
                raeu_pkg::CMD_LOAD:  write_sel(sa, imm);
                raeu_pkg::CMD_MOVR:  write_sel(sa, b);
                raeu_pkg::CMD_ADD:   regs[0] = a + b;
                raeu_pkg::CMD_SUB:   regs[0] = a - b;
                raeu_pkg::CMD_MUL:   regs[0] = a * b;
                raeu_pkg::CMD_MOD, raeu_pkg::CMD_DIV:
                begin
                    if (b == 0)
                    begin
                        dz = 1'b1;
                    end
                    else
                    begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        if (op == raeu_pkg::CMD_DIV)
                        begin
                            r = ma / mb;
                            if (a[31] != b[31]) r = -r;
                        end
                        else
                        begin
                            r = ma % mb;
                            if (a[31]) r = -r;
                        end
                        regs[0] = r;
                    end
                end
                raeu_pkg::CMD_INC:   write_sel(sa, a + 1);
                raeu_pkg::CMD_DEC:   write_sel(sa, a - 1);
                raeu_pkg::CMD_EQ:    regs[0] = (a == b) ? 32'd1 : 32'd0;
                raeu_pkg::CMD_GEQ:   regs[0] = (a < b) ? 32'd0 : 32'd1;
                raeu_pkg::CMD_LEQ:   regs[0] = (b < a) ? 32'd0 : 32'd1;
                raeu_pkg::CMD_GOTO:  pc = a;
                raeu_pkg::CMD_JMPZ:  if (regs[0] == 0) pc = imm;
                raeu_pkg::CMD_JPNZ:  if (regs[0] != 0) pc = imm;
                raeu_pkg::CMD_SHIFT:
                begin
                    if (imm[31])
                    begin
                        n = -imm;
                        if (n > 31) n = 31;
                        write_sel(sa, a << n);
                    end
                    else if (imm != 0)
                    begin
                        n = (imm > 31) ? 32'd31 : imm;
                        write_sel(sa, a >>> n);
                    end
                end
                default: ;
            endcase
            res.acc = regs[0];
            res.pc  = pc;
            res.sp  = sp;
            res.dz  = dz;
            pending.push_back(res);
        endfunction

        // compare one result beat with the oldest expectation
        task check_result(input logic [31:0] acc, input logic [31:0] pcv,
                          input logic [31:0] spv, input logic dzv);
            result_t e;
            if (pending.size() == 0)
            begin
                report_error("result beat with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (acc !== e.acc)
                report_error($sformatf("acc_value %h, expected %h", acc, e.acc));
            if (pcv !== e.pc)
                report_error($sformatf("pc_value %h, expected %h", pcv, e.pc));
            if (spv !== e.sp)
                report_error($sformatf("stack_cursor %h, expected %h", spv, e.sp));
            if (dzv !== e.dz)
                report_error($sformatf("div_zero %b, expected %b", dzv, e.dz));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [4:0]         cmd = '0;
    logic [2:0]         sel_a = '0;
    logic [2:0]         sel_b = '0;
    logic signed [31:0] immediate = '0;
    logic               cfg_we = 1'b0;
    logic [0:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] acc_value;
    logic signed [31:0] pc_value;
    logic signed [31:0] stack_cursor;
    logic               div_zero;

    alu_scoreboard sb = new();
    int  idle_pct_in  = 36;
    int  idle_pct_out = 36;
    bit  hold_out     = 1'b0;
    longint cycle_count = 0;

    register_alu_execute_unit i_dut (.*);

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_register_alu_execute_unit failed");
            $finish;
        end
    end

    // receiver: random ready, checks every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(acc_value, pc_value, stack_cursor, div_zero);
            out_ready <= !hold_out && ($urandom_range(99) >= idle_pct_out);
        end
    end

    // offer one instruction beat and wait until it is taken
    task automatic send_instr(input logic [4:0] op, input logic [2:0] sa,
                              input logic [2:0] sbs, input logic [31:0] imm);
        while ($urandom_range(99) < idle_pct_in)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        sel_a     <= sa;
        sel_b     <= sbs;
        immediate <= imm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_instr(op, sa, sbs, imm);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == raeu_pkg::CFG_CODE_BASE) sb.code_base = v;
        else sb.stack_base = v;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(3) - 1;
            3: return $urandom_range(40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // random instruction mix, weighted toward loads
    task automatic send_random();
        logic [4:0]  op;
        logic [31:0] imm;
        if ($urandom_range(9) < 3) op = raeu_pkg::CMD_LOAD;
        else if ($urandom_range(19) == 0) op = 5'($urandom_range(31));
        else op = 5'($urandom_range(16));
        imm = rand_value();
        if (op == raeu_pkg::CMD_SHIFT && $urandom_range(1)) imm = $urandom_range(80) - 40;
        send_instr(op, 3'($urandom_range(7)), 3'($urandom_range(7)), imm);
    endtask

    initial
    begin
        logic [31:0] bases [4];
        bases = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_cfg(raeu_pkg::CFG_CODE_BASE, 32'h1111_1111);
        write_cfg(raeu_pkg::CFG_STACK_BASE, 32'h2222_2222);

        // directed: extremes, every command, corner cases
        send_instr(raeu_pkg::CMD_LOAD, 3'd1, 3'd0, 32'h8000_0000);
        send_instr(raeu_pkg::CMD_LOAD, 3'd2, 3'd0, 32'hffff_ffff);
        send_instr(raeu_pkg::CMD_DIV, 3'd1, 3'd2, 32'h0);
        send_instr(raeu_pkg::CMD_LOAD, 3'd0, 3'd0, 32'h8000_0000);
        send_instr(raeu_pkg::CMD_MOD, 3'd0, 3'd2, 32'h0);
        send_instr(raeu_pkg::CMD_DIV, 3'd1, 3'd3, 32'h0);
        send_instr(raeu_pkg::CMD_MOD, 3'd1, 3'd4, 32'h0);
        send_instr(raeu_pkg::CMD_LOAD, 3'd3, 3'd0, 32'h7fff_ffff);
        send_instr(raeu_pkg::CMD_LOAD, 3'd4, 3'd0, 32'hffff_fff9);
        send_instr(raeu_pkg::CMD_MOD, 3'd3, 3'd4, 32'h0);
        send_instr(raeu_pkg::CMD_DIV, 3'd4, 3'd3, 32'h0);
        send_instr(raeu_pkg::CMD_MOVR, raeu_pkg::SEL_S, raeu_pkg::SEL_M, 32'h0);
        send_instr(raeu_pkg::CMD_MOVR, raeu_pkg::SEL_M, raeu_pkg::SEL_X, 32'h0);
        send_instr(raeu_pkg::CMD_INC, raeu_pkg::SEL_S, 3'd0, 32'h0);
        send_instr(raeu_pkg::CMD_DEC, 3'd3, 3'd0, 32'h0);
        send_instr(raeu_pkg::CMD_ADD, 3'd3, 3'd1, 32'h0);
        send_instr(raeu_pkg::CMD_SUB, 3'd1, 3'd3, 32'h0);
        send_instr(raeu_pkg::CMD_MUL, 3'd3, 3'd3, 32'h0);
        send_instr(raeu_pkg::CMD_EQ, 3'd1, 3'd1, 32'h0);
        send_instr(raeu_pkg::CMD_GEQ, 3'd1, 3'd3, 32'h0);
        send_instr(raeu_pkg::CMD_LEQ, 3'd1, 3'd3, 32'h0);
        send_instr(raeu_pkg::CMD_GOTO, raeu_pkg::SEL_X, 3'd0, 32'h0);
        send_instr(raeu_pkg::CMD_JPNZ, 3'd0, 3'd0, 32'h3333_3333);
        send_instr(raeu_pkg::CMD_JMPZ, 3'd0, 3'd0, 32'h7fff_ffff);
        send_instr(raeu_pkg::CMD_SHIFT, 3'd1, 3'd0, 32'h0000_0040);
        send_instr(raeu_pkg::CMD_SHIFT, 3'd3, 3'd0, 32'h8000_0000);
        send_instr(raeu_pkg::CMD_SHIFT, 3'd4, 3'd0, 32'h0);
        send_instr(raeu_pkg::CMD_NOP, 3'd0, 3'd0, 32'hffff_ffff);
        send_instr(5'd31, 3'd7, 3'd7, 32'h0);
        wait_drained();

        // random phases, each with fresh base settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_cfg(raeu_pkg::CFG_CODE_BASE, ph < 4 ? bases[ph] : $urandom);
            write_cfg(raeu_pkg::CFG_STACK_BASE, ph < 4 ? bases[3 - ph] : $urandom);
            idle_pct_in  = (ph == 2) ? 0 : 36;
            idle_pct_out = (ph == 2) ? 0 : 36;
            if (ph == 3)
            begin
                // receiver holds off while the sender keeps offering
                fork
                    begin
                        hold_out = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < ITEM_COUNT / 6; i++)
            begin
                send_random();
                if (ph == 4 && i == 150) wait_drained();
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("tb_register_alu_execute_unit passed");
        else
            $display("tb_register_alu_execute_unit failed");
        $finish;
    end
endmodule

// ===== register_alu_execute_unit.f =====
hdl/raeu_pkg.sv
hdl/raeu_front.sv
hdl/raeu_divider.sv
hdl/raeu_back.sv
hdl/register_alu_execute_unit.sv
hdl/raeu_checker.sv
tb/tb_register_alu_execute_unit.sv
